@@ src/mrpt_pkg.sv @@
// Shared types and constants for the 64-bit Miller-Rabin prime test.
package mrpt_pkg;

  localparam int unsigned MaxRoundsDefault = 8;
  localparam int unsigned RoundsReset      = 5;
  localparam int unsigned WordW            = 31;
  localparam int unsigned DataW            = 64;

  typedef enum logic [1:0] {
    MM_MUL = 2'b01,
    MM_RED = 2'b10
  } mm_op_e;

  typedef struct packed {
    logic   start;
    mm_op_e op;
  } mm_req_t;

endpackage

@@ src/mrpt_modmul.sv @@
// Bit-serial modular unit: x*y mod m by double-and-add, or y mod m by restoring shift-subtract.
module mrpt_modmul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mrpt_pkg::mm_req_t           req_i,
  input  logic [mrpt_pkg::DataW-1:0]  x_i,
  input  logic [mrpt_pkg::DataW-1:0]  y_i,
  input  logic [mrpt_pkg::DataW-1:0]  m_i,
  output logic                        done_o,
  output logic [mrpt_pkg::DataW-1:0]  res_o
);

  localparam int unsigned W = mrpt_pkg::DataW;

  logic         busy_q, busy_d;
  logic         red_q, red_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] x_q, x_d;
  logic [W-1:0] y_q, y_d;
  logic [W-1:0] m_q, m_d;
  logic         done_q, done_d;

  logic [W:0]   dbl;
  logic [W-1:0] dbl_r;
  logic [W:0]   add;
  logic [W-1:0] add_r;
  logic [W:0]   sh;

  always_comb begin
    // doubling mod m; acc < m
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? W'(dbl - {1'b0, m_q}) : dbl[W-1:0];
    add   = {1'b0, dbl_r} + {1'b0, x_q};
    add_r = (add >= {1'b0, m_q}) ? W'(add - {1'b0, m_q}) : add[W-1:0];
    sh    = {acc_q, y_q[W-1]};
  end

  always_comb begin
    busy_d = busy_q;
    red_d  = red_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    m_d    = m_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      red_d  = (req_i.op == mrpt_pkg::MM_RED);
      cnt_d  = '1;
      acc_d  = '0;
      x_d    = x_i;
      y_d    = y_i;
      m_d    = m_i;
    end else if (busy_q) begin
      if (red_q) begin
        acc_d = (sh >= {1'b0, m_q}) ? W'(sh - {1'b0, m_q}) : sh[W-1:0];
      end else begin
        acc_d = y_q[W-1] ? add_r : dbl_r;
      end
      y_d   = {y_q[W-2:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q <= red_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

@@ src/miller_rabin_prime_test_64.sv @@
// Top level of the 64-bit Miller-Rabin probable-prime test with its round sequencer.
// One transaction takes a candidate and eight 31-bit random words; candidates below 4
// go straight to the output state. Otherwise n-1 is first split into d * 2^s, then each
// round reduces its witness on the single bit-serial unit, which also does every modular
// multiply of the round; the rounds run one after another on that unit.
// busy is high for the whole test. The result is shown for one cycle with done_o and
// cannot be stalled.
module miller_rabin_prime_test_64 #(
  parameter int unsigned MaxRounds = mrpt_pkg::MaxRoundsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [mrpt_pkg::DataW-1:0]  candidate_i,
  input  logic [mrpt_pkg::WordW-1:0]  random_word_0_i,
  input  logic [mrpt_pkg::WordW-1:0]  random_word_1_i,
  input  logic [mrpt_pkg::WordW-1:0]  random_word_2_i,
  input  logic [mrpt_pkg::WordW-1:0]  random_word_3_i,
  input  logic [mrpt_pkg::WordW-1:0]  random_word_4_i,
  input  logic [mrpt_pkg::WordW-1:0]  random_word_5_i,
  input  logic [mrpt_pkg::WordW-1:0]  random_word_6_i,
  input  logic [mrpt_pkg::WordW-1:0]  random_word_7_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [3:0]                  cfg_rounds_i,
  output logic                        done_o,
  output logic                        probably_prime_o,
  output logic [3:0]                  deciding_round_o,
  output logic                        decided_directly_o
);

  localparam int unsigned W = mrpt_pkg::DataW;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SPLIT = 9'b000000010,
    S_ROUND = 9'b000000100,
    S_WRED  = 9'b000001000,
    S_PMUL  = 9'b000010000,
    S_PSQR  = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_SQR   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]         rounds_q;
  logic [W-1:0]       n_q, n_d;
  logic [W-1:0]       d_q, d_d;
  logic [W-1:0]       e_q, e_d;
  logic [W-1:0]       b_q, b_d;
  logic [W-1:0]       x_q, x_d;
  logic [6:0]         s_q, s_d;
  logic [6:0]         r_q, r_d;
  logic [3:0]         rnd_q, rnd_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [mrpt_pkg::WordW-1:0] words_q [8];
  logic               pp_q, pp_d;
  logic [3:0]         dr_q, dr_d;
  logic               dd_q, dd_d;
  logic               sent_q, sent_d;

  mrpt_pkg::mm_req_t  mm_req;
  logic [W-1:0]       mm_x, mm_y, mm_m;
  logic               mm_done;
  logic [W-1:0]       mm_res;

  logic               accept;
  logic [W-1:0]       nm1;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign nm1         = n_q - W'(1);

  mrpt_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .x_i    (mm_x),
    .y_i    (mm_y),
    .m_i    (mm_m),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  always_comb begin
    state_d = state_q;
    n_d = n_q; d_d = d_q; e_d = e_q; b_d = b_q; x_d = x_q;
    s_d = s_q; r_d = r_q; rnd_d = rnd_q; cnt_d = cnt_q;
    pp_d = pp_q; dr_d = dr_q; dd_d = dd_q;
    sent_d = 1'b0;
    mm_req.start = 1'b0;
    mm_req.op    = mrpt_pkg::MM_MUL;
    mm_x = x_q;
    mm_y = b_q;
    mm_m = n_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          n_d = candidate_i;
          d_d = candidate_i - W'(1);
          s_d = '0;
          rnd_d = '0;
          cnt_d = (rounds_q > 4'(MaxRounds)) ? 4'(MaxRounds) : rounds_q;
          dr_d = 4'd8;
          if (candidate_i < W'(4)) begin
            pp_d = (candidate_i == W'(2)) || (candidate_i == W'(3));
            dd_d = 1'b1;
            state_d = S_OUT;
          end else begin
            pp_d = 1'b1;
            dd_d = 1'b0;
            state_d = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        if (d_q[0]) begin
          state_d = S_ROUND;
        end else begin
          d_d = d_q >> 1;
          s_d = s_q + 7'd1;
        end
      end
      S_ROUND: begin
        if (rnd_q >= cnt_q) begin
          state_d = S_OUT;
        end else begin
          mm_req.start = 1'b1;
          mm_req.op    = mrpt_pkg::MM_RED;
          mm_x = '0;
          mm_y = {33'd0, words_q[rnd_q[2:0]]};
          mm_m = n_q - W'(3);
          state_d = S_WRED;
        end
      end
      S_WRED: begin
        if (mm_done) begin
          b_d = mm_res + W'(2);
          x_d = W'(1);
          e_d = d_q;
          state_d = S_PMUL;
          mm_req.start = 1'b1;
          mm_x = W'(1);
          mm_y = mm_res + W'(2);
        end
      end
      S_PMUL: begin
        if (mm_done) begin
          if (e_q[0]) x_d = mm_res;
          mm_req.start = 1'b1;
          mm_x = b_q;
          mm_y = b_q;
          state_d = S_PSQR;
        end
      end
      S_PSQR: begin
        if (mm_done) begin
          b_d = mm_res;
          e_d = e_q >> 1;
          if ((e_q >> 1) == '0) begin
            r_d = 7'd1;
            state_d = S_CHK;
          end else begin
            mm_req.start = 1'b1;
            mm_x = x_q;
            mm_y = mm_res;
            state_d = S_PMUL;
          end
        end
      end
      S_CHK: begin
        if (x_q == W'(1) || x_q == nm1) begin
          rnd_d = rnd_q + 4'd1;
          state_d = S_ROUND;
        end else if (r_q >= s_q) begin
          pp_d = 1'b0;
          dr_d = rnd_q;
          state_d = S_OUT;
        end else begin
          mm_req.start = 1'b1;
          mm_x = x_q;
          mm_y = x_q;
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        if (mm_done) begin
          x_d = mm_res;
          r_d = r_q + 7'd1;
          if (mm_res == nm1) begin
            rnd_d = rnd_q + 4'd1;
            state_d = S_ROUND;
          end else if (r_q + 7'd1 >= s_q) begin
            pp_d = 1'b0;
            dr_d = rnd_q;
            state_d = S_OUT;
          end else begin
            mm_req.start = 1'b1;
            mm_x = mm_res;
            mm_y = mm_res;
          end
        end
      end
      S_OUT: begin
        sent_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rounds_q <= 4'(mrpt_pkg::RoundsReset);
      sent_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sent_q  <= sent_d;
      if (cfg_valid_i && cfg_ready_o) rounds_q <= cfg_rounds_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; e_q <= e_d; b_q <= b_d; x_q <= x_d;
    s_q <= s_d; r_q <= r_d; rnd_q <= rnd_d; cnt_q <= cnt_d;
    pp_q <= pp_d; dr_q <= dr_d; dd_q <= dd_d;
    if (accept) begin
      words_q[0] <= random_word_0_i;
      words_q[1] <= random_word_1_i;
      words_q[2] <= random_word_2_i;
      words_q[3] <= random_word_3_i;
      words_q[4] <= random_word_4_i;
      words_q[5] <= random_word_5_i;
      words_q[6] <= random_word_6_i;
      words_q[7] <= random_word_7_i;
    end
  end

  assign done_o             = sent_q;
  assign probably_prime_o   = pp_q;
  assign deciding_round_o   = dr_q;
  assign decided_directly_o = dd_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_direct_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && decided_directly_o |-> deciding_round_o == 4'd8) else $error("bad direct round");
  a_prime_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && probably_prime_o |-> deciding_round_o == 4'd8) else $error("bad prime round");

endmodule
